FILE: sv/rts_pkg.sv
package rts_pkg;

    localparam int OP_W = 2;
    localparam int ID_W = 4;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic arm_floor;
        logic arm_write;
        logic disarm;
        logic scan_start;
        logic scan_run;
        logic emit;
        logic emit_ack;
    } rts_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            scan_done;
        logic            any_due;
        logic            last_due;
        logic            out_free;
    } rts_stat_t;

    // input tdata: timer_id, due_time, period, now_time, padded to bytes
    function automatic int in_w(input int time_bits);
        return ((ID_W + 3 * time_bits + 7) / 8) * 8;
    endfunction

    // output tdata: slot, expiry, padded to bytes
    function automatic int out_w(input int time_bits);
        return ((ID_W + time_bits + 7) / 8) * 8;
    endfunction

endpackage

FILE: sv/rts_ctrl.sv
module rts_ctrl
    import rts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rts_stat_t stat,
    output rts_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ARM_FLOOR = 3'd1;
    localparam logic [2:0] S_ARM_WRITE = 3'd2;
    localparam logic [2:0] S_DISARM    = 3'd3;
    localparam logic [2:0] S_ACK       = 3'd4;
    localparam logic [2:0] S_SCAN      = 3'd5;
    localparam logic [2:0] S_EMIT      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    case (stat.in_op)
                        OP_ARM:    state_next = S_ARM_FLOOR;
                        OP_DISARM: state_next = S_DISARM;
                        OP_TICK:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:   state_next = S_ACK;
                    endcase
                end
            end
            S_ARM_FLOOR:
            begin
                cmd.arm_floor = 1'b1;
                state_next    = S_ARM_WRITE;
            end
            S_ARM_WRITE:
            begin
                cmd.arm_write = 1'b1;
                state_next    = S_ACK;
            end
            S_DISARM:
            begin
                cmd.disarm = 1'b1;
                state_next = S_ACK;
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!stat.any_due || stat.last_due)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rts_datapath.sv
module rts_datapath
    import rts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 48
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rts_cmd_t                       cmd,
    output rts_stat_t                      stat,
    input  logic [in_w(TIME_BITS)-1:0]     s_tdata,
    input  logic [OP_W-1:0]                s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [out_w(TIME_BITS)-1:0]    m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam int OUT_W  = out_w(TIME_BITS);
    localparam logic [SLOT_W-1:0]    LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // latched input item
    logic [ID_W-1:0]      id_reg;
    logic [TIME_BITS-1:0] due_in_reg;
    logic [TIME_BITS-1:0] per_in_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] floor_reg;

    // slot table
    logic [TIME_BITS-1:0] due_mem [TIMER_SLOTS];
    logic [TIME_BITS-1:0] per_mem [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] armed_reg;
    logic [TIMER_SLOTS-1:0] pending_reg;

    // scan pipeline
    logic                 scan_act_reg;
    logic [SLOT_W-1:0]    scan_idx_reg;
    logic                 cmp_vld_reg;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [TIME_BITS-1:0] rd_due_reg;
    logic [TIME_BITS-1:0] rd_per_reg;
    logic                 first_reg;

    // best candidate of the current pass
    logic                 best_vld_reg;
    logic [SLOT_W-1:0]    best_idx_reg;
    logic [TIME_BITS-1:0] best_due_reg;
    logic [TIME_BITS-1:0] best_per_reg;
    logic [CNT_W-1:0]     remain_reg;

    // output register
    logic                 m_tvalid_reg;
    logic                 m_fired_reg;
    logic [ID_W-1:0]      m_slot_reg;
    logic [TIME_BITS-1:0] m_exp_reg;
    logic                 m_last_reg;

    logic                 id_ok;
    logic [SLOT_W-1:0]    id_idx;
    logic [TIME_BITS-1:0] arm_due;
    logic [TIME_BITS:0]   sum_w;
    logic [TIME_BITS-1:0] adv_due;
    logic                 issue;
    logic                 cand;
    logic                 better;
    logic                 fire;
    logic                 out_free;
    logic                 due_we;
    logic [SLOT_W-1:0]    due_waddr;
    logic [TIME_BITS-1:0] due_wdata;

    assign id_ok   = int'(id_reg) < TIMER_SLOTS;
    assign id_idx  = SLOT_W'(id_reg);
    assign arm_due = (due_in_reg > floor_reg) ? due_in_reg : floor_reg;
    assign sum_w   = {1'b0, best_due_reg} + {1'b0, best_per_reg};
    assign adv_due = sum_w[TIME_BITS] ? TIME_MAX : sum_w[TIME_BITS-1:0];
    assign issue   = cmd.scan_run && scan_act_reg;
    assign fire    = cmd.emit && (remain_reg != '0);
    assign out_free = !m_tvalid_reg || m_tready;

    assign cand = first_reg ? (armed_reg[cmp_idx_reg] && (rd_due_reg <= now_reg))
                            : pending_reg[cmp_idx_reg];
    // ascending scan with strict less keeps the lower slot on equal due times
    assign better = cand && (!best_vld_reg || (rd_due_reg < best_due_reg));

    assign due_we    = (cmd.arm_write && id_ok) || (fire && (best_per_reg != '0));
    assign due_waddr = cmd.arm_write ? id_idx : best_idx_reg;
    assign due_wdata = cmd.arm_write ? arm_due : adv_due;

    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_waddr] <= due_wdata;
        end
        if (cmd.arm_write && id_ok)
        begin
            per_mem[id_idx] <= per_in_reg;
        end
        if (issue)
        begin
            rd_due_reg <= due_mem[scan_idx_reg];
            rd_per_reg <= per_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            id_reg     <= s_tdata[ID_W-1:0];
            due_in_reg <= s_tdata[ID_W +: TIME_BITS];
            per_in_reg <= s_tdata[ID_W + TIME_BITS +: TIME_BITS];
            now_reg    <= s_tdata[ID_W + 2 * TIME_BITS +: TIME_BITS];
        end
        if (cmd.arm_floor)
        begin
            floor_reg <= (now_reg > per_in_reg) ? (now_reg - per_in_reg) : '0;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_vld_reg && better)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_due_reg <= rd_due_reg;
            best_per_reg <= rd_per_reg;
        end
        if (cmd.emit)
        begin
            m_fired_reg <= fire;
            m_slot_reg  <= fire ? ID_W'(best_idx_reg) : '0;
            m_exp_reg   <= fire ? best_due_reg : '0;
            m_last_reg  <= !fire || (remain_reg == CNT_W'(1));
        end
        else if (cmd.emit_ack)
        begin
            m_fired_reg <= 1'b0;
            m_slot_reg  <= id_reg;
            m_exp_reg   <= '0;
            m_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= '0;
            pending_reg  <= '0;
            scan_act_reg <= 1'b0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            first_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.arm_write && id_ok)
            begin
                armed_reg[id_idx] <= 1'b1;
            end
            if (cmd.disarm && id_ok)
            begin
                armed_reg[id_idx] <= 1'b0;
            end
            // one-shot slots drop out once fired
            if (fire && (best_per_reg == '0))
            begin
                armed_reg[best_idx_reg] <= 1'b0;
            end

            if (cmd.scan_start)
            begin
                scan_act_reg <= 1'b1;
                scan_idx_reg <= '0;
                best_vld_reg <= 1'b0;
            end
            else if (issue)
            begin
                scan_act_reg <= (scan_idx_reg != LAST_IDX);
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            cmp_vld_reg <= issue;

            if (cmp_vld_reg && better)
            begin
                best_vld_reg <= 1'b1;
            end

            if (cmd.load_in)
            begin
                first_reg  <= 1'b1;
                remain_reg <= '0;
            end
            else if (cmd.emit)
            begin
                first_reg <= 1'b0;
            end

            // first pass of a tick takes the due set and counts it
            if (cmp_vld_reg && first_reg)
            begin
                pending_reg[cmp_idx_reg] <= cand;
                if (cand)
                begin
                    remain_reg <= remain_reg + 1'b1;
                end
            end
            if (fire)
            begin
                pending_reg[best_idx_reg] <= 1'b0;
                remain_reg <= remain_reg - 1'b1;
            end

            if (cmd.emit || cmd.emit_ack)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_op     = s_tuser;
    assign stat.scan_done = !scan_act_reg && !cmp_vld_reg;
    assign stat.any_due   = remain_reg != '0;
    assign stat.last_due  = remain_reg == CNT_W'(1);
    assign stat.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_exp_reg, m_slot_reg});
    assign m_tuser  = m_fired_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: sv/recurring_timer_scheduler.sv
// Timer table of TIMER_SLOTS slots (one-shot or periodic) driven by arm, disarm and tick
// items. Arm and disarm give one acknowledge result each. A tick makes one pass over
// all slots per reported timer, reading the single-port due and period memories one
// slot a cycle: with k timers due it returns k fired results in due order (ties to the
// lower slot), or one result with fired clear when nothing is due. A new item is taken
// while the last result still waits in the output register; backpressure on the output
// adds its stall cycles to a tick.
module recurring_timer_scheduler
    import rts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 48
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // timer_id, due_time, period, now_time, zero padded
    input  logic [in_w(TIME_BITS)-1:0]     s_tdata,
    // opcode
    input  logic [OP_W-1:0]                s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot, expiry, zero padded
    output logic [out_w(TIME_BITS)-1:0]    m_tdata,
    // fired
    output logic                           m_tuser,
    output logic                           m_tlast
);

    rts_cmd_t  cmd;
    rts_stat_t stat;

    rts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rts_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/rts_checker.sv
module rts_checker
    import rts_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [out_w(TIME_BITS)-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result changed");

    // acknowledge and nothing-due results are always single
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("non-fired result without last");

    // more fired results of a tick pending, so no new item may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a tick");

    // every item keeps the block busy: ready is low in the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an item");

endmodule

bind recurring_timer_scheduler rts_checker #(
    .TIME_BITS (TIME_BITS)
) u_rts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
